// ===== hdl/jses_pkg.sv =====
package jses_pkg;

  localparam int LANE_COUNT = 16;
  localparam int LANE_IDX_W = 4;
  localparam int COUNT_W    = 5;
  localparam int OUT_POS_W  = 32;

  localparam logic [7:0] ESC_XOR   = 8'h02;
  localparam logic [7:0] ESC_LIMIT = 8'd33;
  localparam logic [7:0] BACKSLASH = 8'h5C;

  typedef struct packed {
    logic [63:0]        chunk_low;
    logic [63:0]        chunk_high;
    logic [COUNT_W-1:0] valid_bytes;
    logic               new_string;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [OUT_POS_W-1:0] position;
    logic [7:0]           escape_byte;
    logic                 last;
  } out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic sel_input;
    logic load;
    logic emit;
    logic drop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic more;
    logic pending;
  } ctrl_status_t;

  function automatic logic is_escape(input logic [7:0] b);
    logic [7:0] x;
    x = b ^ ESC_XOR;
    return (x < ESC_LIMIT) || (b == BACKSLASH);
  endfunction

endpackage

// ===== hdl/json_string_escape_scanner_top.sv =====
// channel | handshake           | payload
// --------+---------------------+--------------------------------
// input   | in_valid / in_ready | in_item  (jses_pkg::in_t)
// output  | out_valid/out_ready | out_item (jses_pkg::out_t)
//
// A chunk with k flagged bytes gives k results; a chunk with none gives one no-match result.
// The single output register is loaded with one result per cycle while the output is not stalled.
// The first result is formed in the cycle the chunk is accepted, the rest from held lanes.
// Synchronous reset clears the running position, the held lane mask and the output valid flag.
// A stalled output holds the result and drops in_ready.
module json_string_escape_scanner_top #(
  parameter int CHUNK_BYTES   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  jses_pkg::in_t  in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output jses_pkg::out_t out_item
);

  jses_pkg::ctrl_cmd_t    cmd;
  jses_pkg::ctrl_status_t status;

  jses_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  jses_datapath #(
    .CHUNK_BYTES   (CHUNK_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_item  (out_item),
    .out_valid (out_valid)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_while_pending: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.pending)
    else $error("input ready while lanes of a chunk remain");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> out_valid)
    else $error("accepted chunk produced no result");

  a_single_result_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !status.more) |=> !status.pending)
    else $error("lanes left over after final result");

  a_nomatch_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.found) |-> (out_item.last && out_item.escape_byte == 8'h00))
    else $error("malformed no-match result");

  a_found_is_escape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.found) |-> jses_pkg::is_escape(out_item.escape_byte))
    else $error("reported byte does not need escaping");
`endif

endmodule

// ===== hdl/jses_ctrl.sv =====
module jses_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     out_ready,
  input  jses_pkg::ctrl_status_t   status,
  output jses_pkg::ctrl_cmd_t      cmd
);

  jses_pkg::state_t state, state_next;
  logic out_can_load;

  assign out_can_load = !status.out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jses_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      jses_pkg::ST_IDLE: begin
        if (in_valid && out_can_load && status.more) begin
          state_next = jses_pkg::ST_DRAIN;
        end
      end
      jses_pkg::ST_DRAIN: begin
        if (out_can_load && !status.more) begin
          state_next = jses_pkg::ST_IDLE;
        end
      end
      default: state_next = jses_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == jses_pkg::ST_IDLE) && out_can_load;
    cmd.sel_input = (state == jses_pkg::ST_IDLE);
    cmd.load      = in_valid && in_ready;
    cmd.emit      = cmd.load || ((state == jses_pkg::ST_DRAIN) && out_can_load);
    cmd.drop      = status.out_valid && out_ready;
  end

endmodule

// ===== hdl/jses_datapath.sv =====
module jses_datapath #(
  parameter int CHUNK_BYTES   = 16,
  parameter int POSITION_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  jses_pkg::in_t          in_item,
  input  jses_pkg::ctrl_cmd_t    cmd,
  output jses_pkg::ctrl_status_t status,
  output jses_pkg::out_t         out_item,
  output logic                   out_valid
);

  localparam int LANES = (CHUNK_BYTES < jses_pkg::LANE_COUNT) ? CHUNK_BYTES
                                                               : jses_pkg::LANE_COUNT;
  localparam int PW    = (POSITION_BITS > jses_pkg::OUT_POS_W) ? POSITION_BITS
                                                               : jses_pkg::OUT_POS_W;
  localparam int NB    = jses_pkg::LANE_COUNT * 8;

  logic [POSITION_BITS-1:0]        byte_position;
  logic [NB-1:0]                   held_bytes;
  logic [jses_pkg::LANE_COUNT-1:0] held_mask;
  logic [POSITION_BITS-1:0]        held_base;

  logic [jses_pkg::COUNT_W-1:0]    count;
  logic [NB-1:0]                   chunk;
  logic [jses_pkg::LANE_COUNT-1:0] in_flags;
  logic [POSITION_BITS-1:0]        start;

  logic [NB-1:0]                   src_bytes;
  logic [jses_pkg::LANE_COUNT-1:0] src_mask;
  logic [POSITION_BITS-1:0]        src_base;
  logic [jses_pkg::LANE_COUNT-1:0] onehot;
  logic [jses_pkg::LANE_COUNT-1:0] rest;
  logic [jses_pkg::LANE_IDX_W-1:0] idx;
  logic [7:0]                      sel_byte;
  logic [POSITION_BITS-1:0]        pos_sum;
  logic [PW-1:0]                   pos_wide;
  jses_pkg::out_t                  result;

  assign count = (in_item.valid_bytes > jses_pkg::COUNT_W'(LANES))
               ? jses_pkg::COUNT_W'(LANES) : in_item.valid_bytes;
  assign chunk = {in_item.chunk_high, in_item.chunk_low};
  assign start = in_item.new_string ? '0 : byte_position;

  always_comb begin
    for (int i = 0; i < jses_pkg::LANE_COUNT; i++) begin
      in_flags[i] = (jses_pkg::COUNT_W'(i) < count) && jses_pkg::is_escape(chunk[i*8 +: 8]);
    end
  end

  assign src_bytes = cmd.sel_input ? chunk    : held_bytes;
  assign src_mask  = cmd.sel_input ? in_flags : held_mask;
  assign src_base  = cmd.sel_input ? start    : held_base;

  assign onehot = src_mask & (~src_mask + jses_pkg::LANE_COUNT'(1));
  assign rest   = src_mask & ~onehot;

  always_comb begin
    idx      = '0;
    sel_byte = '0;
    for (int i = 0; i < jses_pkg::LANE_COUNT; i++) begin
      idx      = idx | (onehot[i] ? jses_pkg::LANE_IDX_W'(i) : '0);
      sel_byte = sel_byte | (src_bytes[i*8 +: 8] & {8{onehot[i]}});
    end
  end

  assign pos_sum  = src_base + POSITION_BITS'(idx);
  assign pos_wide = PW'(pos_sum);

  always_comb begin
    result.found       = |src_mask;
    result.position    = pos_wide[jses_pkg::OUT_POS_W-1:0];
    result.escape_byte = sel_byte;
    result.last        = ~|rest;
  end

  assign status.out_valid = out_valid;
  assign status.more      = |rest;
  assign status.pending   = |held_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      held_mask     <= '0;
      byte_position <= '0;
    end else begin
      if (cmd.emit) begin
        out_valid <= 1'b1;
        held_mask <= rest;
      end else if (cmd.drop) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        byte_position <= start + POSITION_BITS'(count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item <= result;
    end
    if (cmd.load) begin
      held_bytes <= chunk;
      held_base  <= start;
    end
  end

endmodule
